// File: rtl/tga_rle_pixel_encoder_assert.svh
// Assertion macros shared by the run-length encoder modules.
`ifndef TGA_RLE_PIXEL_ENCODER_ASSERT_SVH
`define TGA_RLE_PIXEL_ENCODER_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define TGA_RLE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check that a condition is followed by another in the next cycle.
`define TGA_RLE_ASSERT_NEXT(label, ante, cons, msg) \
    `TGA_RLE_ASSERT(label, (ante) |=> (cons), msg)

`endif

// File: rtl/tga_rle_pkg.sv
// Shared constants, types and helpers of the run-length pixel encoder.
package tga_rle_pkg;

    localparam int PIX_W       = 32;
    localparam int BPP_W       = 3;
    localparam logic [BPP_W-1:0] BPP_RESET = 3'd4;
    localparam int HDR_W       = 8;
    localparam int SIZE_W      = 3;
    localparam int GROUP_N     = 4;
    localparam int GRP_SEL_W   = $clog2(GROUP_N);
    localparam int RUN_BIAS    = 127;

    // Packet buffer geometry: pixels are spread over GROUP_N banks.
    localparam int MAX_PACKET  = 128;
    localparam int CNT_W       = $clog2(MAX_PACKET + 1);
    localparam int ROWS        = (MAX_PACKET + GROUP_N - 1) / GROUP_N;
    localparam int ROW_W       = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int IDX_W       = ROW_W + GRP_SEL_W;
    localparam int REM_W       = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;

    // Open packet kinds.
    localparam int MODE_W = 2;
    localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ONE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RAW  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RUN  = 2'd3;

    // Result transfer layout.
    localparam int OUT_FIELDS_W = HDR_W + GROUP_N * PIX_W + SIZE_W + 2;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

    typedef logic [GROUP_N-1:0][PIX_W-1:0] pix_group_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                 accept;
        logic                 px_we;
        logic [IDX_W-1:0]     px_idx;
        logic                 rd_en;
        logic [ROW_W-1:0]     rd_row;
        logic                 out_load;
        logic                 out_hdr;
        logic [HDR_W-1:0]     out_byte;
        logic                 out_run;
        logic [SIZE_W-1:0]    out_size;
        logic                 out_pend;
        logic                 out_burst;
        logic                 out_img;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic eq;
        logic out_free;
    } dp_stat_t;

    // Byte mask for a pixel width; zero acts as one byte, above four as four.
    function automatic logic [PIX_W-1:0] pixel_mask(input logic [BPP_W-1:0] bpp);
        logic [PIX_W-1:0] m;
        case (bpp) inside
            3'd0, 3'd1: m = 32'h0000_00FF;
            3'd2:       m = 32'h0000_FFFF;
            3'd3:       m = 32'h00FF_FFFF;
            default:    m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

// File: rtl/tga_rle_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tga_rle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                            aclk,
    input  logic                                            we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    waddr,
    input  logic [WIDTH-1:0]                                wdata,
    input  logic                                            re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    raddr,
    output logic [WIDTH-1:0]                                rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read port, data held until the next read.
    always_ff @(posedge aclk) begin
        if (re) begin
            rd_data_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rd_data_reg;

endmodule

// File: rtl/tga_rle_ctrl.sv
// Packet controller: tracks the open packet and sequences header and group transfers.
`include "tga_rle_pixel_encoder_assert.svh"

module tga_rle_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic                   s_tlast,
    input  tga_rle_pkg::dp_stat_t  stat,
    output tga_rle_pkg::dp_cmd_t   cmd
);
    import tga_rle_pkg::*;

    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] ST_IDLE  = 3'd0;
    localparam logic [ST_W-1:0] ST_HDR   = 3'd1;
    localparam logic [ST_W-1:0] ST_RUNPX = 3'd2;
    localparam logic [ST_W-1:0] ST_READ  = 3'd3;
    localparam logic [ST_W-1:0] ST_GRP   = 3'd4;

    logic [ST_W-1:0]   state_reg,     state_next;
    logic [MODE_W-1:0] mode_reg,      mode_next;
    logic [CNT_W-1:0]  count_reg,     count_next;
    logic              cur_run_reg,   cur_run_next;
    logic [CNT_W-1:0]  cur_cnt_reg,   cur_cnt_next;
    logic              nxt_valid_reg, nxt_valid_next;
    logic              nxt_run_reg,   nxt_run_next;
    logic [CNT_W-1:0]  nxt_cnt_reg,   nxt_cnt_next;
    logic              eoi_reg,       eoi_next;
    logic [ROW_W-1:0]  grp_reg,       grp_next;

    // Per-pixel decision
    logic [MODE_W-1:0] acc_mode;
    logic [CNT_W-1:0]  acc_cnt;
    logic              c1_v;
    logic              c1_run;
    logic [CNT_W-1:0]  c1_cnt;
    logic              px_we;
    logic [IDX_W-1:0]  px_idx;
    logic              close_pkt;

    // Group bookkeeping
    logic [REM_W-1:0]  grp_rem;
    logic              grp_last;
    logic [SIZE_W-1:0] grp_size;
    logic [HDR_W-1:0]  hdr_byte;

    // Decide what the offered pixel does to the open packet.
    always_comb begin
        acc_mode = mode_reg;
        acc_cnt  = count_reg;
        c1_v     = 1'b0;
        c1_run   = 1'b0;
        c1_cnt   = count_reg;
        px_we    = 1'b0;
        px_idx   = '0;
        case (mode_reg)
            MODE_ONE: begin
                acc_cnt = CNT_W'(2);
                if (stat.eq) begin
                    acc_mode = MODE_RUN;
                end else begin
                    acc_mode = MODE_RAW;
                    px_we    = 1'b1;
                    px_idx   = IDX_W'(1);
                end
            end
            MODE_RAW: begin
                if (stat.eq) begin
                    // close raw without its last pixel, which starts a run of two
                    c1_v     = 1'b1;
                    c1_cnt   = count_reg - CNT_W'(1);
                    acc_mode = MODE_RUN;
                    acc_cnt  = CNT_W'(2);
                end else begin
                    px_we   = 1'b1;
                    px_idx  = IDX_W'(count_reg);
                    acc_cnt = count_reg + CNT_W'(1);
                end
            end
            MODE_RUN: begin
                if (stat.eq) begin
                    acc_cnt = count_reg + CNT_W'(1);
                end else begin
                    c1_v     = 1'b1;
                    c1_run   = 1'b1;
                    acc_mode = MODE_ONE;
                    acc_cnt  = CNT_W'(1);
                    px_we    = 1'b1;
                end
            end
            default: begin
                acc_mode = MODE_ONE;
                acc_cnt  = CNT_W'(1);
                px_we    = 1'b1;
            end
        endcase
        close_pkt = (acc_cnt >= CNT_W'(MAX_PACKET)) || s_tlast;
    end

    // Group size and header byte of the packet being sent.
    assign grp_rem  = REM_W'(cur_cnt_reg) - REM_W'({grp_reg, {GRP_SEL_W{1'b0}}});
    assign grp_last = grp_rem <= REM_W'(GROUP_N);
    assign grp_size = grp_last ? SIZE_W'(grp_rem) : SIZE_W'(GROUP_N);
    assign hdr_byte = cur_run_reg ? HDR_W'(HDR_W'(cur_cnt_reg) + HDR_W'(RUN_BIAS))
                                  : HDR_W'(cur_cnt_reg - CNT_W'(1));

    assign s_tready = (state_reg == ST_IDLE);

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        count_next     = count_reg;
        cur_run_next   = cur_run_reg;
        cur_cnt_next   = cur_cnt_reg;
        nxt_valid_next = nxt_valid_reg;
        nxt_run_next   = nxt_run_reg;
        nxt_cnt_next   = nxt_cnt_reg;
        eoi_next       = eoi_reg;
        grp_next       = grp_reg;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    cmd.px_we  = px_we;
                    cmd.px_idx = px_idx;
                    mode_next  = close_pkt ? MODE_NONE : acc_mode;
                    count_next = close_pkt ? '0 : acc_cnt;
                    eoi_next   = s_tlast;
                    // first packet to send, and a second one when two close
                    cur_run_next   = c1_v ? c1_run : (acc_mode == MODE_RUN);
                    cur_cnt_next   = c1_v ? c1_cnt : acc_cnt;
                    nxt_valid_next = c1_v && close_pkt;
                    nxt_run_next   = (acc_mode == MODE_RUN);
                    nxt_cnt_next   = acc_cnt;
                    if (c1_v || close_pkt) begin
                        state_next = ST_HDR;
                    end
                end
            end
            ST_HDR: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_hdr  = 1'b1;
                    cmd.out_byte = hdr_byte;
                    grp_next     = '0;
                    state_next   = cur_run_reg ? ST_RUNPX : ST_READ;
                end
            end
            ST_RUNPX: begin
                if (stat.out_free) begin
                    cmd.out_load  = 1'b1;
                    cmd.out_run   = 1'b1;
                    cmd.out_size  = SIZE_W'(1);
                    cmd.out_pend  = 1'b1;
                    cmd.out_burst = !nxt_valid_reg;
                    cmd.out_img   = !nxt_valid_reg && eoi_reg;
                    if (nxt_valid_reg) begin
                        cur_run_next   = nxt_run_reg;
                        cur_cnt_next   = nxt_cnt_reg;
                        nxt_valid_next = 1'b0;
                        state_next     = ST_HDR;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_READ: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_row = grp_reg;
                state_next = ST_GRP;
            end
            ST_GRP: begin
                if (stat.out_free) begin
                    cmd.out_load  = 1'b1;
                    cmd.out_size  = grp_size;
                    cmd.out_pend  = grp_last;
                    cmd.out_burst = grp_last && !nxt_valid_reg;
                    cmd.out_img   = grp_last && !nxt_valid_reg && eoi_reg;
                    if (!grp_last) begin
                        grp_next   = grp_reg + ROW_W'(1);
                        state_next = ST_READ;
                    end else if (nxt_valid_reg) begin
                        cur_run_next   = nxt_run_reg;
                        cur_cnt_next   = nxt_cnt_reg;
                        nxt_valid_next = 1'b0;
                        state_next     = ST_HDR;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_NONE;
            count_reg     <= '0;
            nxt_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            count_reg     <= count_next;
            nxt_valid_reg <= nxt_valid_next;
        end
    end

    // Packet plan
    always_ff @(posedge aclk) begin
        cur_run_reg <= cur_run_next;
        cur_cnt_reg <= cur_cnt_next;
        nxt_run_reg <= nxt_run_next;
        nxt_cnt_reg <= nxt_cnt_next;
        eoi_reg     <= eoi_next;
        grp_reg     <= grp_next;
    end

    `TGA_RLE_ASSERT(a_none_iff_empty, (mode_reg == MODE_NONE) == (count_reg == '0), "open packet and pixel count disagree")
    `TGA_RLE_ASSERT(a_run_count_range, (mode_reg != MODE_RUN) || (count_reg >= CNT_W'(2) && count_reg < CNT_W'(MAX_PACKET)), "run packet count out of range")
    `TGA_RLE_ASSERT_NEXT(a_read_then_group, state_reg == ST_READ, state_reg == ST_GRP, "bank read not followed by group transfer")

endmodule

// File: rtl/tga_rle_dp.sv
// Datapath: width register, pixel compare, banked packet buffer and result register.
`include "tga_rle_pixel_encoder_assert.svh"

module tga_rle_dp (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [tga_rle_pkg::BPP_W-1:0]         cfg_data,
    input  logic [tga_rle_pkg::PIX_W-1:0]         s_tdata,
    input  tga_rle_pkg::dp_cmd_t                  cmd,
    output tga_rle_pkg::dp_stat_t                 stat,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [tga_rle_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                                  m_tuser,
    output logic                                  m_tlast
);
    import tga_rle_pkg::*;

    logic [BPP_W-1:0]  bpp_reg;
    logic [PIX_W-1:0]  prev_reg;
    logic [PIX_W-1:0]  run_val_reg;
    logic [PIX_W-1:0]  mask;
    logic [PIX_W-1:0]  pix_masked;
    pix_group_t        bank_rd;
    pix_group_t        pix_sel;

    logic              m_tvalid_reg;
    logic              hdr_reg;
    logic [HDR_W-1:0]  byte_reg;
    pix_group_t        pix_reg;
    logic [SIZE_W-1:0] size_reg;
    logic              pend_reg;
    logic              burst_reg;
    logic              img_reg;

    // Width register, always ready for a transfer.
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpp_reg <= BPP_RESET;
        end else if (cfg_valid) begin
            bpp_reg <= cfg_data;
        end
    end

    // Mask the incoming pixel and compare it to the last pixel of the packet.
    assign mask       = pixel_mask(bpp_reg);
    assign pix_masked = s_tdata & mask;
    assign stat.eq    = pix_masked == (prev_reg & mask);

    // Last stored pixel and the value a closing run carries.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg <= '0;
        end else if (cmd.px_we) begin
            prev_reg <= pix_masked;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            run_val_reg <= prev_reg;
        end
    end

    // Packet buffer: pixel i lives in bank i mod GROUP_N, so one read fetches a group.
    for (genvar gi = 0; gi < GROUP_N; gi++) begin : g_bank
        tga_rle_ram #(
            .WIDTH (PIX_W),
            .DEPTH (ROWS)
        ) u_ram (
            .aclk  (aclk),
            .we    (cmd.px_we && (cmd.px_idx[GRP_SEL_W-1:0] == GRP_SEL_W'(gi))),
            .waddr (cmd.px_idx[IDX_W-1:GRP_SEL_W]),
            .wdata (pix_masked),
            .re    (cmd.rd_en),
            .raddr (cmd.rd_row),
            .rdata (bank_rd[gi])
        );
    end

    // Select the pixels of the next result; unused slots are zero.
    always_comb begin
        for (int i = 0; i < GROUP_N; i++) begin
            if (cmd.out_hdr) begin
                pix_sel[i] = '0;
            end else if (cmd.out_run) begin
                pix_sel[i] = (i == 0) ? run_val_reg : '0;
            end else begin
                pix_sel[i] = (SIZE_W'(i) < cmd.out_size) ? bank_rd[i] : '0;
            end
        end
    end

    assign stat.out_free = !m_tvalid_reg || m_tready;

    // Result register: load on command, drop once the transfer completes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            hdr_reg   <= cmd.out_hdr;
            byte_reg  <= cmd.out_byte;
            pix_reg   <= pix_sel;
            size_reg  <= cmd.out_size;
            pend_reg  <= cmd.out_pend;
            burst_reg <= cmd.out_burst;
            img_reg   <= cmd.out_img;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = hdr_reg;
    assign m_tlast  = img_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, burst_reg, pend_reg, size_reg,
                       pix_reg[3], pix_reg[2], pix_reg[1], pix_reg[0], byte_reg};

    `TGA_RLE_ASSERT(a_group_size, !m_tvalid_reg || hdr_reg || (size_reg != '0 && size_reg <= SIZE_W'(GROUP_N)), "pixel group with bad size")
    `TGA_RLE_ASSERT(a_header_shape, !m_tvalid_reg || !hdr_reg || (size_reg == '0 && !pend_reg), "header carries pixels or ends packet")
    `TGA_RLE_ASSERT(a_last_flags, !m_tvalid_reg || ((!burst_reg || pend_reg) && (!img_reg || burst_reg)), "burst or image end off a packet end")

endmodule

// File: rtl/tga_rle_pixel_encoder.sv
// Top level of the run-length pixel encoder.
// Run-length pixel encoder: takes one pixel per transfer, groups pixels into raw and run
// packets of up to 128 and sends each closed packet as a header transfer followed by its
// pixels in groups of up to four. A pixel that closes no packet leaves the input ready, and
// the next one is taken in the following cycle. A pixel that closes a packet holds the input
// while the packet goes out: a run packet as a header and then its pixel, a raw packet as a
// header and then, per group, a read of the four packet buffer banks and a load of the
// result register, and a pixel that closes two packets sends both. Back-pressure on the
// result side can stall each of these transfers. A result waiting in the output register
// does not keep a new pixel from being taken. The packet buffer needs no clearing after
// reset. The width register may only be written while no packet is being sent.
module tga_rle_pixel_encoder (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // width register write
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [tga_rle_pkg::BPP_W-1:0]         cfg_data,     // bytes_per_pixel
    // pixel input
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [tga_rle_pkg::PIX_W-1:0]         s_tdata,      // pixel_value
    input  logic                                  s_tlast,      // end_of_image
    // encoded output
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // header_byte[7:0], pixel_a[39:8], pixel_b[71:40], pixel_c[103:72],
    // pixel_d[135:104], group_size[138:136], packet_end[139], burst_last[140], zero
    output logic [tga_rle_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                                  m_tuser,      // is_header
    output logic                                  m_tlast       // image_end
);
    import tga_rle_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    tga_rle_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tlast  (s_tlast),
        .stat     (stat),
        .cmd      (cmd)
    );

    tga_rle_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
